[hdl/kpi_pkg.sv]
package kpi_pkg;

    localparam int CORDIC_ITERS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_STEPS = (CORDIC_ITERS < ATAN_ENTRIES) ? CORDIC_ITERS : ATAN_ENTRIES;
    localparam int ITER_W       = $clog2(ATAN_ENTRIES);

    localparam int PI_Q         = 205887;
    localparam int TWO_PI_Q     = 411775;
    localparam int HALF_PI_Q    = 102944;
    localparam int CORDIC_GAIN  = 652032874;
    localparam int WRAP_K_MAX   = 5;
    localparam int WRAP_BIAS    = (TWO_PI_Q << WRAP_K_MAX) + PI_Q;

    localparam logic [15:0] TIME_STEP_RESET = 16'd6554;

    typedef struct packed {
        logic               first_of_run;
        logic signed [31:0] start_speed;
        logic signed [15:0] accel;
        logic signed [15:0] yaw_rate;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_V,
        S_MUL_H,
        S_WRAP_INIT,
        S_WRAP,
        S_CORDIC_INIT,
        S_CORDIC,
        S_MUL_X,
        S_MUL_Y,
        S_ACC_Y,
        S_OUT
    } t_state;

    // arctangent of 2^-i in Q16.16
    function automatic logic [15:0] atan_q16(input logic [ITER_W-1:0] idx);
        logic [15:0] v;
        unique case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[hdl/kinematic_path_integrator.sv]
// channel | direction | handshake                  | word
// input   | in        | i_in_valid / o_in_ready    | kpi_pkg::t_in_word
// result  | out       | o_out_valid / i_out_ready  | kpi_pkg::t_out_word
// config  | in        | i_cfg_we (no wait)         | time_step, 16 bit
//
// one word is processed from acceptance to result by the sequencer
// around one shared 33x33 multiplier, a six-step compare/subtract heading
// wrap and CORDIC_ITERS cordic steps on one shift/add unit.
// a new word is accepted in the cycle after the result is loaded, even while
// that result still waits on i_out_ready; a stalled result holds the loop.
// synchronous active-low reset: state cleared, time_step back to 6554.
module kinematic_path_integrator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kpi_pkg::t_in_word i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output kpi_pkg::t_out_word o_out_data
);
    import kpi_pkg::*;

    t_state r_state, n_state;

    logic [15:0]         r_time_step;
    logic signed [31:0]  r_x, r_y, r_speed, r_heading;
    logic signed [15:0]  r_accel, r_rate;
    logic signed [65:0]  r_prod;
    logic [24:0]         r_w;
    logic [2:0]          r_k;
    logic signed [31:0]  r_cx, r_cy;
    logic signed [19:0]  r_z;
    logic                r_flip;
    logic [ITER_W-1:0]   r_i;
    logic signed [31:0]  r_dist;
    logic                r_out_valid;
    t_out_word           r_out_data;

    logic                c_mul_en;
    logic signed [32:0]  c_mul_a, c_mul_b;
    logic signed [31:0]  c_cos, c_sin;
    logic signed [26:0]  c_wrap_sum;
    logic [24:0]         c_wsub;
    logic signed [31:0]  c_h, c_zred;
    logic signed [31:0]  c_dx, c_dy;
    logic signed [19:0]  c_at;
    logic                c_in_acc;
    logic                c_out_load;

    assign c_in_acc   = i_in_valid && o_in_ready;
    assign c_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign c_cos      = r_flip ? -r_cx : r_cx;
    assign c_sin      = r_flip ? -r_cy : r_cy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:        if (i_in_valid) n_state = S_MUL_V;
            S_MUL_V:       n_state = S_MUL_H;
            S_MUL_H:       n_state = S_WRAP_INIT;
            S_WRAP_INIT:   n_state = S_WRAP;
            S_WRAP:        if (r_k == 3'd0) n_state = S_CORDIC_INIT;
            S_CORDIC_INIT: n_state = S_CORDIC;
            S_CORDIC:      if (r_i == ITER_W'(CORDIC_STEPS - 1)) n_state = S_MUL_X;
            S_MUL_X:       n_state = S_MUL_Y;
            S_MUL_Y:       n_state = S_ACC_Y;
            S_ACC_Y:       n_state = S_OUT;
            S_OUT:         if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // control outputs and multiplier operand select
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        c_mul_en   = 1'b0;
        c_mul_a    = '0;
        c_mul_b    = $signed({17'b0, r_time_step});
        unique case (r_state)
            S_MUL_V: begin
                c_mul_en = 1'b1;
                c_mul_a  = 33'(r_accel);
            end
            S_MUL_H: begin
                c_mul_en = 1'b1;
                c_mul_a  = 33'(r_rate);
            end
            S_WRAP_INIT: begin
                c_mul_en = 1'b1;
                c_mul_a  = 33'(r_speed);
            end
            S_MUL_X: begin
                c_mul_en = 1'b1;
                c_mul_a  = 33'(c_cos);
                c_mul_b  = 33'(r_dist);
            end
            S_MUL_Y: begin
                c_mul_en = 1'b1;
                c_mul_a  = 33'(c_sin);
                c_mul_b  = 33'(r_dist);
            end
            default: begin
                c_mul_en = 1'b0;
            end
        endcase
    end

    // datapath helpers
    always_comb begin
        // heading plus step, biased so the remainder search starts non-negative
        c_wrap_sum = $signed(r_heading[26:0]) + 27'($signed(r_prod[32:8]))
                     + 27'(WRAP_BIAS);
        c_wsub     = 25'(TWO_PI_Q) << r_k;
        c_h        = $signed({7'b0, r_w}) - 32'(PI_Q);
        if (c_h > 32'(HALF_PI_Q)) begin
            c_zred = c_h - 32'(PI_Q);
        end else if (c_h < -32'(HALF_PI_Q)) begin
            c_zred = c_h + 32'(PI_Q);
        end else begin
            c_zred = c_h;
        end
        c_dx = r_cy >>> r_i;
        c_dy = r_cx >>> r_i;
        c_at = $signed({4'b0, atan_q16(r_i)});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time_step <= TIME_STEP_RESET;
            r_x         <= '0;
            r_y         <= '0;
            r_speed     <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_time_step <= i_cfg_data;
            if (c_mul_en) r_prod <= c_mul_a * c_mul_b;
            if (c_out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (c_in_acc) begin
                        r_accel <= i_in_data.accel;
                        r_rate  <= i_in_data.yaw_rate;
                        if (i_in_data.first_of_run) begin
                            r_x       <= '0;
                            r_y       <= '0;
                            r_heading <= '0;
                            r_speed   <= i_in_data.start_speed;
                        end
                    end
                end
                S_MUL_H: begin
                    r_speed <= sat32(36'(r_speed) + 36'($signed(r_prod[40:8])));
                end
                S_WRAP_INIT: begin
                    r_w <= c_wrap_sum[24:0];
                    r_k <= 3'(WRAP_K_MAX);
                end
                S_WRAP: begin
                    if (r_w >= c_wsub) r_w <= r_w - c_wsub;
                    r_k <= r_k - 3'd1;
                end
                S_CORDIC_INIT: begin
                    r_heading <= c_h;
                    r_z       <= c_zred[19:0];
                    r_flip    <= (c_zred != c_h);
                    r_cx      <= 32'(CORDIC_GAIN);
                    r_cy      <= '0;
                    r_i       <= '0;
                    r_dist    <= r_prod[47:16];
                end
                S_CORDIC: begin
                    if (!r_z[19]) begin
                        r_cx <= r_cx - c_dx;
                        r_cy <= r_cy + c_dy;
                        r_z  <= r_z - c_at;
                    end else begin
                        r_cx <= r_cx + c_dx;
                        r_cy <= r_cy - c_dy;
                        r_z  <= r_z + c_at;
                    end
                    r_i <= r_i + ITER_W'(1);
                end
                S_MUL_Y: begin
                    r_x <= sat32(36'(r_x) + 36'($signed(r_prod[63:30])));
                end
                S_ACC_Y: begin
                    r_y <= sat32(36'(r_y) + 36'($signed(r_prod[63:30])));
                end
                S_OUT: begin
                    if (c_out_load) begin
                        r_out_data.pos_x <= r_x;
                        r_out_data.pos_y <= r_y;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hdl/kpi_checker.sv]
module kpi_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input kpi_pkg::t_out_word o_out_data
);
    import kpi_pkg::*;

    // reset leaves the block empty and ready for a word
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("result valid or input not ready after reset");

    // one word at a time: accepting a word drops ready
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an accepted word");

    // a result never shows up in the cycle right after its word is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result valid without time for the step");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

endmodule

bind kinematic_path_integrator kpi_checker u_kpi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[test/kinematic_path_integrator_test.sv]
`timescale 1ns / 1ps

module kinematic_path_integrator_test;

    import kpi_pkg::*;

    localparam int  HALF_PERIOD   = 6;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  BLOCK_ITEMS   = 115;
    localparam int  BLOCKS        = 4;
    localparam int  TAIL_CYCLES   = 40;
    localparam int  PRINT_CAP     = 100;
    localparam int  Q16_MAX       = 32'h7fffffff;
    localparam int  Q16_MIN       = 32'h80000000;

    typedef struct {
        logic [15:0] dt;
        t_in_word    word;
        bit          typed;
        t_out_word   want;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [15:0] cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_data;

    // track state of the vehicle, mirrors the block
    int          trk_x;
    int          trk_y;
    int          trk_speed;
    int          trk_heading;
    logic [15:0] step_dt;

    t_out_word pending_pos[$];
    t_dir_row  dir_rows[$];
    longint    atan_lut [24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2,
                                  1, 0, 0, 0, 0, 0, 0, 0};

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    kinematic_path_integrator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int clamp_q16(input longint v);
        int r;
        if (v > longint'(Q16_MAX)) begin
            r = Q16_MAX;
        end else if (v < longint'(Q16_MIN)) begin
            r = Q16_MIN;
        end else begin
            r = int'(v);
        end
        return r;
    endfunction

    // one euler step of the unicycle, returns the new position
    function automatic t_out_word advance_track(input t_in_word w);
        longint    dtl;
        longint    wr;
        longint    cx;
        longint    sy;
        longint    zz;
        longint    dx;
        longint    dy;
        longint    step_len;
        bit        flip;
        t_out_word r;
        dtl = longint'({48'd0, step_dt});
        if (w.first_of_run) begin
            trk_x       = 0;
            trk_y       = 0;
            trk_heading = 0;
            trk_speed   = w.start_speed;
        end
        trk_speed = clamp_q16(longint'(trk_speed) + ((longint'(w.accel) * dtl) >>> 8));
        wr = (longint'(trk_heading) + ((longint'(w.yaw_rate) * dtl) >>> 8) + PI_Q)
             % TWO_PI_Q;
        if (wr < 0) begin
            wr += TWO_PI_Q;
        end
        trk_heading = int'(wr - PI_Q);

        // fold into the right half plane, then rotate
        cx   = CORDIC_GAIN;
        sy   = 0;
        zz   = trk_heading;
        flip = 1'b0;
        if (zz > HALF_PI_Q) begin
            zz -= PI_Q;
            flip = 1'b1;
        end else if (zz < -HALF_PI_Q) begin
            zz += PI_Q;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (zz >= 0) begin
                cx -= dx;
                sy += dy;
                zz -= atan_lut[i];
            end else begin
                cx += dx;
                sy -= dy;
                zz += atan_lut[i];
            end
        end
        if (flip) begin
            cx = -cx;
            sy = -sy;
        end

        step_len = (longint'(trk_speed) * dtl) >>> 16;
        trk_x = clamp_q16(longint'(trk_x) + ((cx * step_len) >>> 30));
        trk_y = clamp_q16(longint'(trk_y) + ((sy * step_len) >>> 30));
        r.pos_x = trk_x;
        r.pos_y = trk_y;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
        end
    endtask

    // result side: random stall, compare against oldest expected position
    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_pos.size() == 0) begin
                report_mismatch("unexpected word", out_data.pos_x, '0);
            end else begin
                want = pending_pos.pop_front();
                if (out_data.pos_x !== want.pos_x) begin
                    report_mismatch("pos_x", out_data.pos_x, want.pos_x);
                end
                if (out_data.pos_y !== want.pos_y) begin
                    report_mismatch("pos_y", out_data.pos_y, want.pos_y);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic feed_word(input t_in_word w, input bit typed, input t_out_word want);
        t_out_word p;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = advance_track(w);
        pending_pos = {pending_pos, (typed ? want : p)};
    endtask

    // hold the sender off until every expected position has come back
    task automatic drain_positions();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_pos.size() != 0);
    endtask

    task automatic write_time_step(input logic [15:0] v);
        drain_positions();
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        step_dt = v;
    endtask

    function automatic logic [15:0] random_q8();
        int pick;
        logic [15:0] v;
        pick = $urandom_range(9);
        if (pick < 3) begin
            v = 16'($urandom);
        end else if (pick == 3) begin
            v = $urandom_range(1) ? 16'h7fff : 16'h8000;
        end else begin
            v = 16'(int'($urandom_range(2048)) - 1024);
        end
        return v;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int pick;
        w.first_of_run = ($urandom_range(15) == 0);
        pick = $urandom_range(9);
        if (pick < 3) begin
            w.start_speed = $urandom;
        end else if (pick == 3) begin
            w.start_speed = $urandom_range(1) ? Q16_MAX : Q16_MIN;
        end else begin
            w.start_speed = int'($urandom_range(2621440)) - 1310720;
        end
        w.accel    = random_q8();
        w.yaw_rate = random_q8();
        return w;
    endfunction

    function automatic t_dir_row dir_row(input logic [15:0] dt, input bit first, input int speed,
                                         input int accel, input int yaw, input bit typed,
                                         input int wx, input int wy);
        t_dir_row r;
        r.dt                 = dt;
        r.word.first_of_run  = first;
        r.word.start_speed   = speed;
        r.word.accel         = accel[15:0];
        r.word.yaw_rate      = yaw[15:0];
        r.typed              = typed;
        r.want.pos_x         = wx;
        r.want.pos_y         = wy;
        return r;
    endfunction

    function automatic void add_row(input t_dir_row r);
        dir_rows = {dir_rows, r};
    endfunction

    initial begin
        t_dir_row  row;
        t_out_word none;
        logic [15:0] dt_pick;
        int blk;

        none        = '0;
        step_dt     = TIME_STEP_RESET;
        trk_x       = 0;
        trk_y       = 0;
        trk_speed   = 0;
        trk_heading = 0;

        // reset state: start speed is ignored without first_of_run, nothing moves; then runs at the reset time step
        add_row(dir_row(16'd6554, 1'b0, Q16_MAX, 0, 0, 1'b1, 0, 0));
        add_row(dir_row(16'd6554, 1'b1, 32'h00010000, 0, 0, 1'b0, 0, 0));
        add_row(dir_row(16'd6554, 1'b0, 0, 32767, 32767, 1'b0, 0, 0));
        add_row(dir_row(16'd6554, 1'b0, 0, -32768, -32768, 1'b0, 0, 0));
        add_row(dir_row(16'd6554, 1'b1, -65536, 256, -256, 1'b0, 0, 0));
        add_row(dir_row(16'd6554, 1'b0, 0, 0, 32767, 1'b0, 0, 0));
        // zero time step leaves the position where it is
        add_row(dir_row(16'd0, 1'b1, Q16_MAX, 32767, 32767, 1'b1, 0, 0));
        add_row(dir_row(16'd0, 1'b0, Q16_MIN, -32768, -32768, 1'b1, 0, 0));
        // full step, speed and position run into the limits
        add_row(dir_row(16'hffff, 1'b1, Q16_MAX, 32767, 0, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, 32767, 0, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, 32767, 0, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b1, Q16_MIN, -32768, 0, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, -32768, 0, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, -32768, 0, 1'b0, 0, 0));
        // headings on both sides of half pi and near pi, then full-scale turns and the smallest nonzero time step
        add_row(dir_row(16'hffff, 1'b1, 32'h00640000, 0, 402, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b1, 32'h00640000, 0, 403, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b1, 32'h00640000, 0, -402, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b1, 32'h00640000, 0, -403, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b1, 32'h00640000, 0, 804, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, 0, 32767, 1'b0, 0, 0));
        add_row(dir_row(16'hffff, 1'b0, 0, 0, -32768, 1'b0, 0, 0));
        add_row(dir_row(16'd1, 1'b1, 32'h00010000, 1, -1, 1'b0, 0, 0));
        add_row(dir_row(16'd1, 1'b0, 0, -1, 1, 1'b0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.dt != step_dt) begin
                write_time_step(row.dt);
            end
            feed_word(row.word, row.typed, row.want);
        end

        blk = 0;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 65 : 0;
            recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 15 : 0;
            for (int b = 0; b < BLOCKS; b++) begin
                case (blk % 6)
                    0: begin
                        dt_pick = TIME_STEP_RESET;
                    end
                    1: begin
                        dt_pick = 16'($urandom_range(65535));
                    end
                    2: begin
                        dt_pick = 16'hffff;
                    end
                    3: begin
                        dt_pick = 16'($urandom_range(64, 1));
                    end
                    4: begin
                        dt_pick = 16'd0;
                    end
                    default: begin
                        dt_pick = 16'($urandom_range(65535));
                    end
                endcase
                write_time_step(dt_pick);
                blk++;
                for (int n = 0; n < BLOCK_ITEMS; n++) begin
                    if (ph == 0 && b == 1 && n == BLOCK_ITEMS / 2) begin
                        drain_positions();
                    end
                    feed_word(random_word(), 1'b0, none);
                end
            end
        end

        drain_positions();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/kpi_pkg.sv
hdl/kinematic_path_integrator.sv
hdl/kpi_checker.sv
test/kinematic_path_integrator_test.sv
